[rtl/stable_min_priority_queue_defines.svh]
// Assertion macros shared by the queue's checker.
`ifndef STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_MIN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SMPQ_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("smpq: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("smpq: next-cycle check failed");

`endif

[rtl/smpq_pkg.sv]
// Types and codes shared by the priority queue files.
`timescale 1ns / 1ps

package smpq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 32;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // One stored entry: priority in the upper half, value below.
    typedef struct packed {
        logic signed [PRIO_W-1:0]  prio;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[rtl/stable_min_priority_queue.sv]
// Overflow, underflow and insert into an empty queue register their result with busy
// staying low. Remove passes through S_DEL; insert walks S_CMP back over the stored entries
// with a larger priority, then S_WNEW if every entry moved. Both register their result as
// busy falls. A new transfer is taken as soon as busy is low. The walk is set by
// the one compare unit and the single RAM write port. Results cannot be stalled.
// Reset (synchronous, active low) empties the queue at once; the RAM needs no clearing.
`timescale 1ns / 1ps

module stable_min_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic signed [31:0]          i_item_value,
    input  logic signed [31:0]          i_priority_req,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic signed [31:0]          o_out_value,
    output logic signed [31:0]          o_out_priority,
    output logic [4:0]                  o_fill_count
);

    // Address width of the store and width of a count that can hold CAPACITY itself.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // The store is a ring: logical slot 0 (the front) sits at r_head.
    // Insert walks back from the tail, moving each larger-priority entry up one slot
    // until it meets one that is less or equal, then drops the new item in behind it.
    // Ties therefore stay in arrival order. Remove just reads the head and advances it.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,   // compare entry at r_idx with the new item, shift or place
        S_WNEW,  // every entry moved up: new item goes to the front
        S_DEL    // head entry on the read port
    } t_state;

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_idx, n_idx;
    smpq_pkg::t_entry       r_new, n_new;
    logic                   r_valid, n_valid;
    smpq_pkg::t_status      r_status, n_status;
    logic signed [31:0]     r_value, n_value;
    logic signed [31:0]     r_prio, n_prio;

    logic                   w_accept;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr;
    smpq_pkg::t_entry       w_wdata;
    smpq_pkg::t_entry       w_rdata;
    logic [smpq_pkg::ENTRY_W-1:0] w_rdata_raw;
    logic                   w_greater;
    logic [CW-1:0]          w_last;
    logic [AW-1:0]          w_idx_dn;
    logic [CW+4:0]          w_fill_ext;

    // Logical slot to RAM address; both operands stay below CAPACITY.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] lidx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    smpq_ram #(
        .WIDTH (smpq_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata  = smpq_pkg::t_entry'(w_rdata_raw);
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // The one shared compare: signed priority of the stored entry against the new one.
    assign w_greater = (w_rdata.prio > r_new.prio);

    assign w_last   = r_count - CW'(1);
    assign w_idx_dn = (r_idx != '0) ? (r_idx - AW'(1)) : '0;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_new    = r_new;
        n_valid  = 1'b0;
        n_status = r_status;
        n_value  = r_value;
        n_prio   = r_prio;
        w_we     = 1'b0;
        w_waddr  = r_head;
        w_wdata  = r_new;
        w_raddr  = r_head;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_new.prio  = i_priority_req;
                    n_new.value = i_item_value;
                    n_value     = '0;
                    n_prio      = '0;
                    if (i_action == smpq_pkg::ACT_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_valid  = 1'b1;
                            n_status = smpq_pkg::ST_OVERFLOW;
                        end else if (r_count == '0) begin
                            w_we          = 1'b1;
                            w_waddr       = r_head;
                            w_wdata.prio  = i_priority_req;
                            w_wdata.value = i_item_value;
                            n_count       = r_count + CW'(1);
                            n_valid       = 1'b1;
                            n_status      = smpq_pkg::ST_INSERTED;
                        end else begin
                            n_idx   = w_last[AW-1:0];
                            w_raddr = f_phys(r_head, w_last[AW-1:0]);
                            n_state = S_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_valid  = 1'b1;
                            n_status = smpq_pkg::ST_UNDERFLOW;
                        end else begin
                            w_raddr = r_head;
                            n_state = S_DEL;
                        end
                    end
                end
            end
            S_CMP: begin
                w_we    = 1'b1;
                w_waddr = f_phys(r_head, r_idx + AW'(1));
                if (w_greater) begin
                    // move this entry up one slot and look at the next one down
                    w_wdata = w_rdata;
                    if (r_idx == '0) begin
                        n_state = S_WNEW;
                    end else begin
                        n_idx   = w_idx_dn;
                        w_raddr = f_phys(r_head, w_idx_dn);
                    end
                end else begin
                    w_wdata  = r_new;
                    n_count  = r_count + CW'(1);
                    n_valid  = 1'b1;
                    n_status = smpq_pkg::ST_INSERTED;
                    n_state  = S_IDLE;
                end
            end
            S_WNEW: begin
                w_we     = 1'b1;
                w_waddr  = r_head;
                w_wdata  = r_new;
                n_count  = r_count + CW'(1);
                n_valid  = 1'b1;
                n_status = smpq_pkg::ST_INSERTED;
                n_state  = S_IDLE;
            end
            S_DEL: begin
                n_value  = w_rdata.value;
                n_prio   = w_rdata.prio;
                n_head   = f_phys(r_head, AW'(1));
                n_count  = r_count - CW'(1);
                n_valid  = 1'b1;
                n_status = smpq_pkg::ST_REMOVED;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_status <= n_status;
        r_value  <= n_value;
        r_prio   <= n_prio;
    end

    // Fill count carries the low five bits of the entry count.
    assign w_fill_ext = (CW+5)'(r_count);

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_value;
    assign o_out_priority = r_prio;
    assign o_fill_count   = w_fill_ext[4:0];

endmodule

[rtl/smpq_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module smpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/smpq_checker.sv]
// Port-level checks for the priority queue, bound to its top level.
`timescale 1ns / 1ps
`include "stable_min_priority_queue_defines.svh"

module smpq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [31:0] o_out_value,
    input logic [31:0] o_out_priority,
    input logic [4:0]  o_fill_count
);

    // An accepted transfer is followed by a result or by the busy phase.
    `SMPQ_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, o_valid || busy)

    // Leaving the busy phase always delivers the result in that cycle.
    `SMPQ_ASSERT_IMPLY(a_done_on_fall, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_valid)

    // Only a removal carries a value and priority.
    `SMPQ_ASSERT_IMPLY(a_zero_payload, i_clk, i_rst_n,
        o_valid && (o_status != smpq_pkg::ST_REMOVED),
        (o_out_value == 32'd0) && (o_out_priority == 32'd0))

    // Underflow is only reported on an empty queue.
    `SMPQ_ASSERT_IMPLY(a_underflow_empty, i_clk, i_rst_n,
        o_valid && (o_status == smpq_pkg::ST_UNDERFLOW), o_fill_count == 5'd0)

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_out_value    (o_out_value),
    .o_out_priority (o_out_priority),
    .o_fill_count   (o_fill_count)
);
